[sv/wdms_pkg.sv]
// shared constants and types of the wave-digital mosfet switch
`default_nettype none
package wdms_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 20;
   localparam int REG_WIDTH = 31;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAMMA = 2'd2;

   typedef enum logic [1:0] {
      REGION_OFF    = 2'd0,
      REGION_TRIODE = 2'd1,
      REGION_SAT    = 2'd2
   } region_type;
endpackage
`default_nettype wire

[sv/wave_digital_mosfet_switch.sv]
// top level of the wave-digital mosfet switch element
//
// usage
//  - req channel: one beat carries incident waves a1, a2 and the gate bit;
//    accepted on a clock edge with req_valid high and req_stall low
//  - rsp channel: one beat per request, in order, with reflected waves
//    b1 = sat(a1 - i), b2 = sat(a2 + i) and the operating region
//  - csr port: csr_write with csr_index selects alpha (0), beta (1) or
//    gamma (2); other indexes are ignored; write only while idle
//  - throughput: one beat per cycle, fully pipelined, unless a rsp beat is held
//  - a beat goes through stages 1 to 4, the bit-per-stage root pipeline,
//    stage 5, the bit-per-stage divide pipeline, stages 6 to 8 and then
//    the output register
//  - when rsp_stall holds a waiting beat, the whole pipeline freezes and
//    req_stall rises in the same cycle; nothing is dropped or repeated
//  - reset clears all valid bits and loads alpha 2.0, beta 1.0, gamma 1.0
`default_nettype none
module wave_digital_mosfet_switch #(
   parameter int DATA_WIDTH = wdms_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = wdms_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [DATA_WIDTH-1:0]           req_incident_wave_one,
   input  wire logic signed [DATA_WIDTH-1:0]           req_incident_wave_two,
   input  wire logic                                   req_gate_on,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [DATA_WIDTH-1:0]                rsp_reflected_wave_one,
   output logic signed [DATA_WIDTH-1:0]                rsp_reflected_wave_two,
   output logic [1:0]                                  rsp_region,
   input  wire logic                                   csr_write,
   input  wire logic [wdms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [wdms_pkg::REG_WIDTH-1:0]         csr_data
);
   localparam int DW   = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int GW   = wdms_pkg::REG_WIDTH;
   localparam int XW   = DW + GW - F;                    // normalized voltage
   localparam int CW   = ((GW > F) ? GW : F) + 1;        // beta + one, d
   localparam int KW   = (XW > CW) ? XW : CW;
   localparam int PPW  = GW + CW - F;                    // p
   localparam int SW   = ((PPW + 2 > F + 1) ? PPW + 2 : F + 1) + 1;
   localparam int RADW = SW + F;
   localparam int QW   = (RADW + 1) / 2;                 // root width
   localparam int DVW  = ((QW > F + 1) ? QW : F + 1) + 1;
   localparam int NW   = CW + 1 + F;
   localparam int QDW  = F + 2;
   localparam int EW   = ((DW > GW) ? DW : GW) + 2;
   localparam int SSQ  = CW + 2 + 2 * DW;
   localparam int SDV  = 2 + 2 * DW;

   localparam logic [GW-1:0]    ALPHA_RST = GW'(64'd2 << F);
   localparam logic [GW-1:0]    UNIT_RST  = GW'(64'd1 << F);
   localparam logic [CW-1:0]    ONE_C     = CW'(1) << F;
   localparam logic [SW-1:0]    ONE_S     = SW'(1) << F;
   localparam logic [DVW-1:0]   ONE_D     = DVW'(1) << F;
   localparam logic [QDW-1:0]   ONE_Q     = QDW'(1) << F;
   localparam logic [F:0]       ONE_U     = (F+1)'(1) << F;
   localparam logic signed [EW-1:0] SMAX  = EW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [EW-1:0] SMIN  = -SMAX - EW'(1);

   // configuration registers
   logic [GW-1:0] alpha_ff, beta_ff, gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RST;
         beta_ff  <= UNIT_RST;
         gamma_ff <= UNIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            wdms_pkg::CSR_ALPHA: alpha_ff <= csr_data;
            wdms_pkg::CSR_BETA:  beta_ff  <= csr_data;
            wdms_pkg::CSR_GAMMA: gamma_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // one enable for the whole pipeline: it moves unless the output beat is held
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // stage 1: capture and difference a = a1 - a2
   logic                 v1_ff;
   logic signed [DW-1:0] a1_s1_ff, a2_s1_ff;
   logic signed [DW:0]   diff_s1_ff;
   logic                 gate_s1_ff;

   // stage 2: x = a * alpha
   logic                 v2_ff;
   logic [DW+GW-1:0]     prod_ax;
   logic [XW-1:0]        x_s2_ff;
   logic                 on_s2_ff;
   logic signed [DW-1:0] a1_s2_ff, a2_s2_ff;

   // stage 3: region decision and d = one + beta - x
   logic                 v3_ff;
   logic [CW-1:0]        bone;
   logic                 sat_c;
   logic [CW-1:0]        d_c;
   wdms_pkg::region_type region_c;
   logic [CW-1:0]        d_s3_ff;
   wdms_pkg::region_type region_s3_ff;
   logic signed [DW-1:0] a1_s3_ff, a2_s3_ff;

   // stage 4: s = 4 * floor(beta * d) + one
   logic                 v4_ff;
   logic [GW+CW-1:0]     prod_bd;
   logic [SW-1:0]        s_c;
   logic [SW-1:0]        s_s4_ff;
   logic [CW-1:0]        d_s4_ff;
   wdms_pkg::region_type region_s4_ff;
   logic signed [DW-1:0] a1_s4_ff, a2_s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign prod_ax = (DW+GW)'(diff_s1_ff[DW-1:0]) * (DW+GW)'(alpha_ff);
   assign bone    = CW'(beta_ff) + ONE_C;
   assign sat_c   = KW'(x_s2_ff) >= KW'(bone);
   assign d_c     = CW'(KW'(bone) - KW'(x_s2_ff));
   assign prod_bd = (GW+CW)'(beta_ff) * (GW+CW)'(d_s3_ff);
   assign s_c     = (SW'(prod_bd[GW+CW-1:F]) << 2) + ONE_S;

   always_comb begin
      if (!on_s2_ff) begin
         region_c = wdms_pkg::REGION_OFF;
      end else if (sat_c) begin
         region_c = wdms_pkg::REGION_SAT;
      end else begin
         region_c = wdms_pkg::REGION_TRIODE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_s1_ff     <= req_incident_wave_one;
         a2_s1_ff     <= req_incident_wave_two;
         diff_s1_ff   <= (DW+1)'(req_incident_wave_one) - (DW+1)'(req_incident_wave_two);
         gate_s1_ff   <= req_gate_on;

         x_s2_ff      <= prod_ax[DW+GW-1:F];
         on_s2_ff     <= gate_s1_ff && !diff_s1_ff[DW];
         a1_s2_ff     <= a1_s1_ff;
         a2_s2_ff     <= a2_s1_ff;

         d_s3_ff      <= d_c;
         region_s3_ff <= region_c;
         a1_s3_ff     <= a1_s2_ff;
         a2_s3_ff     <= a2_s2_ff;

         s_s4_ff      <= s_c;
         d_s4_ff      <= d_s3_ff;
         region_s4_ff <= region_s3_ff;
         a1_s4_ff     <= a1_s3_ff;
         a2_s4_ff     <= a2_s3_ff;
      end
   end

   // r = floor(sqrt(s * one)), one bit per stage
   logic           sq_valid;
   logic [QW-1:0]  sq_root;
   logic [SSQ-1:0] sq_side;

   wdms_isqrt #(
      .RAD_W  (RADW),
      .SIDE_W (SSQ)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (en),
      .in_valid    (v4_ff),
      .in_radicand ({s_s4_ff, {F{1'b0}}}),
      .in_side     ({d_s4_ff, region_s4_ff, a1_s4_ff, a2_s4_ff}),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // stage 5: divider operands n = 2d * one, den = one + r
   logic           v5_ff;
   logic [CW-1:0]  sq_d;
   logic [1:0]     sq_region;
   logic [NW-1:0]  num_s5_ff;
   logic [DVW-1:0] den_s5_ff;
   logic [SDV-1:0] side_s5_ff;

   assign sq_d      = sq_side[SSQ-1 -: CW];
   assign sq_region = sq_side[2*DW+1 -: 2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_s5_ff  <= {sq_d, 1'b0, {F{1'b0}}};
         den_s5_ff  <= DVW'(sq_root) + ONE_D;
         side_s5_ff <= {sq_region, sq_side[2*DW-1:0]};
      end
   end

   // u = floor(n / den), F+2 quotient bits plus overflow
   logic           dv_valid;
   logic [QDW-1:0] dv_quo;
   logic           dv_ovf;
   logic [SDV-1:0] dv_side;

   wdms_div #(
      .NUM_W  (NW),
      .DEN_W  (DVW),
      .Q_W    (QDW),
      .SIDE_W (SDV)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (v5_ff),
      .in_num    (num_s5_ff),
      .in_den    (den_s5_ff),
      .in_side   (side_s5_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf),
      .out_side  (dv_side)
   );

   // stage 6: clamp u to one
   logic                 v6_ff;
   logic [F:0]           u_s6_ff;
   wdms_pkg::region_type region_s6_ff;
   logic signed [DW-1:0] a1_s6_ff, a2_s6_ff;

   // stage 7: y = one - u^2, chosen by region
   logic                 v7_ff;
   logic [2*F+1:0]       uu;
   logic [F+1:0]         ytri;
   logic [F:0]           y_c;
   logic [F:0]           y_s7_ff;
   wdms_pkg::region_type region_s7_ff;
   logic signed [DW-1:0] a1_s7_ff, a2_s7_ff;

   // stage 8: i = y * gamma
   logic                 v8_ff;
   logic [F+GW:0]        prod_yg;
   logic [GW-1:0]        cur_s8_ff;
   wdms_pkg::region_type region_s8_ff;
   logic signed [DW-1:0] a1_s8_ff, a2_s8_ff;

   // output register: saturated reflected waves
   logic signed [EW-1:0] b1_c, b2_c;
   logic signed [DW-1:0] b1_sat, b2_sat;
   logic signed [DW-1:0] b1_ff, b2_ff;
   logic [1:0]           region_ff;

   assign uu      = (2*F+2)'(u_s6_ff) * (2*F+2)'(u_s6_ff);
   assign ytri    = ONE_Q - uu[2*F+1:F];
   assign prod_yg = (F+GW+1)'(y_s7_ff) * (F+GW+1)'(gamma_ff);

   always_comb begin
      case (region_s6_ff)
         wdms_pkg::REGION_OFF:    y_c = '0;
         wdms_pkg::REGION_TRIODE: y_c = ytri[F:0];
         wdms_pkg::REGION_SAT:    y_c = ONE_U;
         default:                 y_c = '0;
      endcase
   end

   assign b1_c = EW'(a1_s8_ff) - $signed(EW'(cur_s8_ff));
   assign b2_c = EW'(a2_s8_ff) + $signed(EW'(cur_s8_ff));

   always_comb begin
      if (b1_c > SMAX) begin
         b1_sat = DW'(SMAX);
      end else if (b1_c < SMIN) begin
         b1_sat = DW'(SMIN);
      end else begin
         b1_sat = DW'(b1_c);
      end
      if (b2_c > SMAX) begin
         b2_sat = DW'(SMAX);
      end else if (b2_c < SMIN) begin
         b2_sat = DW'(SMIN);
      end else begin
         b2_sat = DW'(b2_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v6_ff        <= dv_valid;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         rsp_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_s6_ff      <= (dv_ovf || dv_quo > ONE_Q) ? ONE_U : dv_quo[F:0];
         region_s6_ff <= wdms_pkg::region_type'(dv_side[SDV-1 -: 2]);
         a1_s6_ff     <= dv_side[2*DW-1:DW];
         a2_s6_ff     <= dv_side[DW-1:0];

         y_s7_ff      <= y_c;
         region_s7_ff <= region_s6_ff;
         a1_s7_ff     <= a1_s6_ff;
         a2_s7_ff     <= a2_s6_ff;

         cur_s8_ff    <= prod_yg[F+GW-1:F];
         region_s8_ff <= region_s7_ff;
         a1_s8_ff     <= a1_s7_ff;
         a2_s8_ff     <= a2_s7_ff;

         b1_ff        <= b1_sat;
         b2_ff        <= b2_sat;
         region_ff    <= region_s8_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_reflected_wave_one = b1_ff;
   assign rsp_reflected_wave_two = b2_ff;
   assign rsp_region             = region_ff;

`ifndef SYNTHESIS
   // input is held back only while a finished beat waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a waiting rsp beat");

   // clamped u never exceeds one
   a_u_bound: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> u_s6_ff <= ONE_U)
      else $error("u above one");

   // current stays within gamma
   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      v8_ff |-> cur_s8_ff <= gamma_ff)
      else $error("current above gamma");

   // gate off or negative voltage gives no current
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (v8_ff && region_s8_ff == wdms_pkg::REGION_OFF) |-> cur_s8_ff == '0)
      else $error("current in off region");
`endif
endmodule
`default_nettype wire

[sv/wdms_isqrt.sv]
// pipelined floor square root, one root bit per stage
`default_nettype none
module wdms_isqrt #(
   parameter int RAD_W  = 66,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_radicand,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [(RAD_W+1)/2-1:0] out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int QW  = (RAD_W + 1) / 2;
   localparam int PW  = 2 * QW;
   localparam int RMW = QW + 1;

   logic [PW-1:0]     rad_ff  [QW];
   logic [RMW-1:0]    rem_ff  [QW+1];
   logic [QW-1:0]     root_ff [QW+1];
   logic [SIDE_W-1:0] side_ff [QW+1];
   logic [QW:0]       vld_ff;

   logic [RMW+1:0]    rem_sh  [QW];
   logic [RMW+1:0]    trial   [QW];
   logic [RMW-1:0]    rem_in  [QW];
   logic [QW-1:0]     root_in [QW];

   // one pair of radicand bits per stage
   always_comb begin
      for (int i = 0; i < QW; i++) begin
         rem_sh[i] = {rem_ff[i], rad_ff[i][PW-1 -: 2]};
         trial[i]  = {1'b0, root_ff[i], 2'b01};
         if (rem_sh[i] >= trial[i]) begin
            rem_in[i]  = RMW'(rem_sh[i] - trial[i]);
            root_in[i] = {root_ff[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_sh[i][RMW-1:0];
            root_in[i] = {root_ff[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff[0]  <= PW'(in_radicand);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
         for (int i = 0; i < QW - 1; i++) begin
            rad_ff[i+1] <= rad_ff[i] << 2;
         end
         for (int i = 0; i < QW; i++) begin
            rem_ff[i+1]  <= rem_in[i];
            root_ff[i+1] <= root_in[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_root  = root_ff[QW];
   assign out_side  = side_ff[QW];
endmodule
`default_nettype wire

[sv/wdms_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module wdms_div #(
   parameter int NUM_W  = 53,
   parameter int DEN_W  = 34,
   parameter int Q_W    = 22,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [Q_W-1:0]         out_quo,
   output logic                   out_ovf,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int CMPW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
   localparam int NS   = Q_W + 2;

   logic [CMPW-1:0]   rem_ff  [NS];
   logic [DEN_W-1:0]  den_ff  [NS];
   logic [Q_W-1:0]    q_ff    [NS];
   logic              ovf_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [NS-1:0]     vld_ff;

   logic [CMPW-1:0]   trial   [Q_W];
   logic              ge      [Q_W];
   logic [CMPW-1:0]   rem_nx  [Q_W];
   logic [Q_W-1:0]    q_nx    [Q_W];

   always_comb begin
      for (int j = 0; j < Q_W; j++) begin
         trial[j]  = CMPW'(den_ff[j+1]) << (Q_W - 1 - j);
         ge[j]     = rem_ff[j+1] >= trial[j];
         rem_nx[j] = ge[j] ? rem_ff[j+1] - trial[j] : rem_ff[j+1];
         q_nx[j]   = {q_ff[j+1][Q_W-2:0], ge[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= CMPW'(in_num);
         den_ff[0]  <= in_den;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= 1'b0;
         side_ff[0] <= in_side;
         // quotient would not fit in Q_W bits
         rem_ff[1]  <= rem_ff[0];
         den_ff[1]  <= den_ff[0];
         q_ff[1]    <= '0;
         ovf_ff[1]  <= rem_ff[0] >= (CMPW'(den_ff[0]) << Q_W);
         side_ff[1] <= side_ff[0];
         for (int j = 0; j < Q_W; j++) begin
            rem_ff[j+2]  <= rem_nx[j];
            den_ff[j+2]  <= den_ff[j+1];
            q_ff[j+2]    <= q_nx[j];
            ovf_ff[j+2]  <= ovf_ff[j+1];
            side_ff[j+2] <= side_ff[j+1];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = q_ff[NS-1];
   assign out_ovf   = ovf_ff[NS-1];
   assign out_side  = side_ff[NS-1];
endmodule
`default_nettype wire
